[src/pmi_pkg.sv]
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared types, codes and sizes of the page marker indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package pmi_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int AW          = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = 10;
    localparam int MEM_W       = 64;   // {offset, page number}

    localparam int S_TDATA_W   = 56;   // 50 payload bits, padded to bytes
    localparam int M_TDATA_W   = 88;   // 86 payload bits, padded to bytes

    // item kinds on s_axis_tuser
    localparam logic [2:0] MODE_BYTE  = 3'd0;
    localparam logic [2:0] MODE_EOS   = 3'd1;
    localparam logic [2:0] MODE_CLEAR = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_FIND  = 3'd4;

    // result status on m_axis_tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic             recorded;
        logic [IDX_W-1:0] index;
        logic [31:0]      offset;
        logic [31:0]      number;
        logic [CNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic             en;
        logic [AW-1:0]    addr;
        logic [MEM_W-1:0] data;
    } t_mem_wr;

endpackage

`default_nettype wire

[src/pmi_ram.sv]
// ----------------------------------------------------------------------------
// pmi_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmi_ram #(
    parameter int DW    = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/pmi_scan.sv]
// ----------------------------------------------------------------------------
// pmi_scan
// Byte stream parser: finds page markers, reads the page number and issues
// table writes. Also handles end of stream and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module pmi_scan (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_stb,
    input  wire logic [2:0]            i_mode,
    input  wire logic [7:0]            i_byte,
    output pmi_pkg::t_result           o_res,
    output pmi_pkg::t_mem_wr           o_wr,
    output logic [pmi_pkg::CNT_W-1:0]  o_count
);

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [6:0] {
        PH_NORMAL   = 7'b0000001,
        PH_AFTER_NL = 7'b0000010,
        PH_WS       = 7'b0000100,
        PH_SIGN     = 7'b0001000,
        PH_DIGITS   = 7'b0010000,
        PH_SKIP     = 7'b0100000,
        PH_STOPPED  = 7'b1000000
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [31:0]                r_pos, n_pos;
    logic [31:0]                r_acc, n_acc;
    logic                       r_neg, n_neg;
    logic [31:0]                r_held, n_held;
    logic [pmi_pkg::CNT_W-1:0]  r_count, n_count;

    logic        do_commit;
    logic        is_ws, is_digit, is_sign, full;
    logic [31:0] acc_next;

    // acc*10 +/- digit, saturated to the signed 32-bit range
    function automatic logic [31:0] add_digit(input logic [31:0] acc,
                                              input logic [7:0]  c,
                                              input logic        neg);
        logic [35:0] ext;
        logic [35:0] prod;
        logic [35:0] d;
        ext  = {{4{acc[31]}}, acc};
        prod = (ext << 3) + (ext << 1);
        d    = 36'(c - CH_ZERO);
        prod = neg ? prod - d : prod + d;
        if ($signed(prod) > 36'sd2147483647) begin
            add_digit = 32'h7FFF_FFFF;
        end else if ($signed(prod) < -36'sd2147483648) begin
            add_digit = 32'h8000_0000;
        end else begin
            add_digit = prod[31:0];
        end
    endfunction

    assign is_ws    = (i_byte == 8'h20) || (i_byte >= 8'h09 && i_byte <= 8'h0D);
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= 8'h39);
    assign is_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
    assign full     = (32'(r_count) >= 32'(pmi_pkg::MAX_ENTRIES));
    assign acc_next = add_digit(r_acc, i_byte, r_neg);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_held    = r_held;
        n_count   = r_count;
        do_commit = 1'b0;
        o_res     = '0;
        o_wr      = '0;

        case (i_mode)
            pmi_pkg::MODE_BYTE: begin
                if (r_phase == PH_STOPPED) begin
                    o_res.status = pmi_pkg::ST_FULL;
                end else begin
                    n_pos = r_pos + 32'd1;
                    case (r_phase)
                        PH_AFTER_NL: begin
                            if (i_byte == CH_P) begin
                                if (full) begin
                                    n_phase      = PH_STOPPED;
                                    o_res.status = pmi_pkg::ST_FULL;
                                end else begin
                                    n_phase = PH_WS;
                                end
                            end else if (i_byte != CH_LF) begin
                                n_phase = PH_NORMAL;
                            end
                        end
                        PH_WS: begin
                            if (is_ws) begin
                                n_phase = PH_WS;
                            end else if (is_sign) begin
                                n_neg   = (i_byte == CH_MINUS);
                                n_acc   = '0;
                                n_phase = PH_SIGN;
                            end else if (is_digit) begin
                                n_neg   = 1'b0;
                                n_acc   = 32'(i_byte - CH_ZERO);
                                n_phase = PH_DIGITS;
                            end else if (i_byte == CH_LF) begin
                                do_commit = 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_SIGN: begin
                            if (is_digit) begin
                                n_acc   = acc_next;
                                n_phase = PH_DIGITS;
                            end else if (i_byte == CH_LF) begin
                                do_commit = 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_DIGITS: begin
                            if (is_digit) begin
                                n_acc = acc_next;
                            end else begin
                                n_held = r_acc;
                                if (i_byte == CH_LF) begin
                                    do_commit = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                        PH_SKIP: begin
                            if (i_byte == CH_LF) begin
                                do_commit = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = (i_byte == CH_LF) ? PH_AFTER_NL : PH_NORMAL;
                        end
                    endcase
                end
            end
            pmi_pkg::MODE_EOS: begin
                if (r_phase == PH_DIGITS) begin
                    n_held = r_acc;
                end
                if (r_phase == PH_WS || r_phase == PH_SIGN ||
                    r_phase == PH_DIGITS || r_phase == PH_SKIP) begin
                    do_commit = 1'b1;
                end else if (r_phase == PH_STOPPED) begin
                    o_res.status = pmi_pkg::ST_FULL;
                end
            end
            pmi_pkg::MODE_CLEAR: begin
                n_held  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase

        // a marker line is closed: record (offset, number), or report full
        if (do_commit) begin
            n_phase = PH_NORMAL;
            if (full) begin
                o_res.status = pmi_pkg::ST_FULL;
            end else begin
                o_wr.en        = 1'b1;
                o_wr.addr      = r_count[pmi_pkg::AW-1:0];
                o_wr.data      = {n_pos, n_held};
                o_res.recorded = 1'b1;
                o_res.index    = pmi_pkg::IDX_W'(r_count);
                o_res.offset   = n_pos;
                o_res.number   = n_held;
                n_count        = r_count + pmi_pkg::CNT_W'(1);
            end
        end

        if (i_mode == pmi_pkg::MODE_EOS || i_mode == pmi_pkg::MODE_CLEAR) begin
            n_phase = PH_NORMAL;
            n_pos   = '0;
            n_acc   = '0;
            n_neg   = 1'b0;
        end

        o_res.count = n_count;
        if (!i_stb) begin
            o_wr.en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_pos   <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_held  <= '0;
            r_count <= '0;
        end else if (i_stb) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

[src/page_marker_indexer.sv]
// ----------------------------------------------------------------------------
// page_marker_indexer
// Page marker table builder and lookup, top level.
// ----------------------------------------------------------------------------
// Stream bytes, end of stream, clear and unused modes are answered straight
// from the parser, so a byte stream runs at one transaction per clock while the
// result side keeps up. A read entry goes through one registered RAM read. A
// find page walks the table through the single read port of the entry RAM, one
// entry per cycle, until a match or entry_count entries. Results leave through
// an output register; input is taken in idle state while that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module page_marker_indexer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] byte_value, [17:8] entry_index, [49:18] target_number, zero pad
    input  wire logic [pmi_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] mode
    input  wire logic [2:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] entry_recorded, [10:1] found_index, [42:11] offset,
    // [74:43] page_number, [85:75] entry_count, zero pad
    output logic      [pmi_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic      [1:0]                     m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_FIND = 3'b100
    } t_state;

    localparam int AW    = pmi_pkg::AW;
    localparam int CNT_W = pmi_pkg::CNT_W;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_addr, n_addr;
    logic [CNT_W-1:0]           r_left, n_left;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]              r_cmp_addr, n_cmp_addr;
    logic [31:0]                r_target, n_target;
    logic                       r_out_vld;
    pmi_pkg::t_result           r_out;

    logic                       accept;
    logic [2:0]                 in_mode;
    logic [7:0]                 in_byte;
    logic [pmi_pkg::IDX_W-1:0]  in_idx;
    logic [31:0]                in_target;

    logic                       scan_stb;
    pmi_pkg::t_result           scan_res;
    pmi_pkg::t_mem_wr           wr;
    logic [CNT_W-1:0]           count;
    logic [AW-1:0]              raddr;
    logic [pmi_pkg::MEM_W-1:0]  rdata;

    logic                       ld;
    pmi_pkg::t_result           ld_res;
    logic [CNT_W-1:0]           cur_nxt;
    logic [CNT_W-1:0]           addr_nxt;

    assign in_byte   = s_axis_tdata[7:0];
    assign in_idx    = s_axis_tdata[17:8];
    assign in_target = s_axis_tdata[49:18];
    assign in_mode   = s_axis_tuser;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_vld || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign scan_stb      = accept && (in_mode != pmi_pkg::MODE_READ) &&
                           (in_mode != pmi_pkg::MODE_FIND);

    pmi_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stb   (scan_stb),
        .i_mode  (in_mode),
        .i_byte  (in_byte),
        .o_res   (scan_res),
        .o_wr    (wr),
        .o_count (count)
    );

    pmi_ram #(
        .DW    (pmi_pkg::MEM_W),
        .DEPTH (pmi_pkg::MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign raddr    = (r_state == S_IDLE) ? AW'(in_idx) : r_addr;
    assign cur_nxt  = CNT_W'(in_idx) + CNT_W'(1);
    assign addr_nxt = CNT_W'(r_addr) + CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_left     = r_left;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_addr = r_cmp_addr;
        n_target   = r_target;
        ld         = 1'b0;
        ld_res     = '0;
        ld_res.count = count;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        pmi_pkg::MODE_BYTE, pmi_pkg::MODE_EOS,
                        pmi_pkg::MODE_CLEAR: begin
                            ld     = 1'b1;
                            ld_res = scan_res;
                        end
                        pmi_pkg::MODE_READ: begin
                            if (32'(in_idx) < 32'(count)) begin
                                n_addr  = AW'(in_idx);
                                n_state = S_READ;
                            end else begin
                                ld            = 1'b1;
                                ld_res.status = pmi_pkg::ST_RANGE;
                            end
                        end
                        pmi_pkg::MODE_FIND: begin
                            // walk all valid entries, starting after entry_index (at entry 0 if out of range)
                            if (32'(in_idx) < 32'(count) && cur_nxt != count) begin
                                n_addr = AW'(cur_nxt);
                            end else begin
                                n_addr = '0;
                            end
                            n_left    = count;
                            n_cmp_vld = 1'b0;
                            n_target  = in_target;
                            n_state   = S_FIND;
                        end
                        default: begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                ld            = 1'b1;
                ld_res.index  = pmi_pkg::IDX_W'(r_addr);
                ld_res.offset = rdata[63:32];
                ld_res.number = rdata[31:0];
                n_state       = S_IDLE;
            end
            S_FIND: begin
                if (r_cmp_vld && rdata[31:0] == r_target) begin
                    ld            = 1'b1;
                    ld_res.index  = pmi_pkg::IDX_W'(r_cmp_addr);
                    ld_res.offset = rdata[63:32];
                    ld_res.number = rdata[31:0];
                    n_state       = S_IDLE;
                end else if (r_left != '0) begin
                    n_cmp_vld  = 1'b1;
                    n_cmp_addr = r_addr;
                    n_addr     = (addr_nxt == count) ? '0 : AW'(addr_nxt);
                    n_left     = r_left - CNT_W'(1);
                end else begin
                    ld            = 1'b1;
                    ld_res.status = pmi_pkg::ST_NOTFOUND;
                    ld_res.index  = '1;
                    n_cmp_vld     = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            if (ld) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_cmp_addr <= n_cmp_addr;
        r_target   <= n_target;
        if (ld) begin
            r_out <= ld_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {2'b00, 11'(r_out.count), r_out.number, r_out.offset,
                            r_out.index, r_out.recorded};

endmodule

`default_nettype wire
